// ===== sv/tfc_pkg.sv =====
package tfc_pkg;

    localparam int FORCE_W  = 20;
    localparam int SPEED_W  = 16;
    localparam int EFF_W    = 16;
    localparam int STF_W    = 24;
    localparam int SLIP_W   = 16;
    localparam int POWER_W  = 22;
    localparam int REGION_W = 2;
    localparam int GRAV_W   = 20;
    localparam int SPH_W    = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int SPEED_FRAC_BITS_DEF = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EFF_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EFF_HIGH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TO_FREQ = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP_FREQ_TWO = 3'd6;

    // curve regions
    localparam logic [REGION_W-1:0] REGION_CONST  = 2'd0;
    localparam logic [REGION_W-1:0] REGION_INTERP = 2'd1;
    localparam logic [REGION_W-1:0] REGION_INVSQ  = 2'd2;

    localparam logic [FORCE_W-1:0] FORCE_MAX = 20'd1048575;
    localparam logic [POWER_W-1:0] POWER_MAX = 22'd4194303;
    localparam logic [GRAV_W-1:0]  GRAV_Q16  = 20'd642689;
    localparam logic [SPH_W-1:0]   SEC_PER_HOUR = 12'd3600;

    localparam logic [EFF_W-1:0]  EFF_LOW_RST  = 16'd62259;
    localparam logic [EFF_W-1:0]  EFF_HIGH_RST = 16'd58982;
    localparam logic [SLIP_W-1:0] SLIP_RST     = 16'd1638;

endpackage

// ===== sv/traction_force_curve_unit.sv =====
// Path: a speed sample accepted with start passes through five chained bit-per-stage dividers
// (interpolation, force, two frequency ratio steps, power) and the multiply and rounding stages
// around them before its result is on the outputs.
// Throughput: one speed sample per cycle; busy is never raised.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults.
module traction_force_curve_unit
    import tfc_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [SPEED_W-1:0]    speed,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [FORCE_W-1:0]    force_res,
    output logic [POWER_W-1:0]    power,
    output logic [REGION_W-1:0]   region
);

    localparam int SFB     = SPEED_FRAC_BITS;
    localparam int PROD_W  = STF_W + SPEED_W;
    localparam int SH_W    = PROD_W - 8 - SFB + 1;
    localparam int FREQ_W  = SH_W + 1;
    localparam int STEP_W  = 2 * EFF_W;
    localparam int NUMA_W  = FORCE_W + SPEED_W + EFF_W;
    localparam int DENA_W  = SPEED_W + EFF_W;
    localparam int TN_W    = FORCE_W + FREQ_W;
    localparam int PD0_W   = EFF_W + SPH_W;
    localparam int PDEN_W  = PD0_W + SFB;
    localparam int PW1_W   = FORCE_W + SPEED_W;
    localparam int PW_W    = PW1_W + GRAV_W;
    localparam logic [PROD_W:0] HALF_F = (PROD_W+1)'(1) << (7 + SFB);

    typedef struct packed {
        logic [NUMA_W-1:0]   num_a;
        logic [FREQ_W-1:0]   freq;
        logic [FREQ_W-1:0]   freq_two;
        logic [SPEED_W-1:0]  v;
        logic [REGION_W-1:0] rgn;
    } side_i_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq;
        logic [FREQ_W-1:0]   freq_two;
        logic [SPEED_W-1:0]  v;
        logic [REGION_W-1:0] rgn;
        logic [EFF_W-1:0]    eff;
    } side_a_t;

    typedef struct packed {
        logic [FORCE_W-1:0]  force_e;
        logic [FREQ_W-1:0]   freq;
        logic [FREQ_W-1:0]   freq_two;
        logic [SPEED_W-1:0]  v;
        logic [REGION_W-1:0] rgn;
        logic [EFF_W-1:0]    eff;
    } side_b_t;

    typedef struct packed {
        logic [FORCE_W-1:0]  force_e;
        logic                fz;
        logic [SPEED_W-1:0]  v;
        logic [REGION_W-1:0] rgn;
        logic [EFF_W-1:0]    eff;
    } side_c_t;

    typedef struct packed {
        logic [FORCE_W-1:0]  frc;
        logic [REGION_W-1:0] rgn;
    } side_p_t;

    // configuration
    logic [FORCE_W-1:0] max_force_reg;
    logic [SPEED_W-1:0] speed_one_reg;
    logic [SPEED_W-1:0] speed_two_reg;
    logic [EFF_W-1:0]   eff_low_reg;
    logic [EFF_W-1:0]   eff_high_reg;
    logic [STF_W-1:0]   stf_reg;
    logic [SLIP_W-1:0]  slip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_force_reg <= '0;
            speed_one_reg <= '0;
            speed_two_reg <= '0;
            eff_low_reg   <= EFF_LOW_RST;
            eff_high_reg  <= EFF_HIGH_RST;
            stf_reg       <= '0;
            slip_reg      <= SLIP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MAX_FORCE:     max_force_reg <= cfg_data[FORCE_W-1:0];
                CFG_SPEED_ONE:     speed_one_reg <= cfg_data[SPEED_W-1:0];
                CFG_SPEED_TWO:     speed_two_reg <= cfg_data[SPEED_W-1:0];
                CFG_EFF_LOW:       eff_low_reg   <= cfg_data[EFF_W-1:0];
                CFG_EFF_HIGH:      eff_high_reg  <= cfg_data[EFF_W-1:0];
                CFG_SPEED_TO_FREQ: stf_reg       <= cfg_data[STF_W-1:0];
                CFG_SLIP_FREQ_TWO: slip_reg      <= cfg_data[SLIP_W-1:0];
                default:           ;
            endcase
        end
    end

    // derived from configuration; the user must keep it static while items are in flight (not enforced here)
    logic [EFF_W-1:0]   e1;
    logic [EFF_W-1:0]   e2;
    logic               eff_falls;
    logic [EFF_W-1:0]   eff_span;
    logic [SPEED_W-1:0] speed_span;
    logic [SPEED_W-1:0] s1_sel;
    logic [SPEED_W-1:0] s2_sel;

    assign e1         = (eff_low_reg == '0) ? EFF_W'(1) : eff_low_reg;
    assign e2         = (eff_high_reg == '0) ? EFF_W'(1) : eff_high_reg;
    assign eff_falls  = e2 < e1;
    assign eff_span   = eff_falls ? (e1 - e2) : (e2 - e1);
    assign speed_span = speed_two_reg - speed_one_reg;
    // zero speed_two: the speed ratio counts as one
    assign s1_sel     = (speed_two_reg == '0) ? SPEED_W'(1) : speed_one_reg;
    assign s2_sel     = (speed_two_reg == '0) ? SPEED_W'(1) : speed_two_reg;

    assign busy = 1'b0;

    logic [REGION_W-1:0] rgn_in;

    always_comb
    begin
        if (speed < speed_one_reg)
            rgn_in = REGION_CONST;
        else if (speed < speed_two_reg && speed_one_reg < speed_two_reg)
            rgn_in = REGION_INTERP;
        else
            rgn_in = REGION_INVSQ;
    end

    // stage A
    logic                a_vld_reg;
    logic [SPEED_W-1:0]  a_v_reg;
    logic [REGION_W-1:0] a_rgn_reg;
    // stage B
    logic                b_vld_reg;
    logic [SPEED_W-1:0]  b_v_reg;
    logic [REGION_W-1:0] b_rgn_reg;
    logic [STEP_W-1:0]   b_step_reg;
    logic [PW1_W-1:0]    b_f0s1_reg;
    logic [PROD_W-1:0]   b_fprod_reg;
    logic [PROD_W-1:0]   b_f2prod_reg;
    // stage C
    logic                c_vld_reg;
    logic [SPEED_W-1:0]  c_v_reg;
    logic [REGION_W-1:0] c_rgn_reg;
    logic [STEP_W-1:0]   c_step_reg;
    logic [NUMA_W-1:0]   c_numa_reg;
    logic [FREQ_W-1:0]   c_freq_reg;
    logic [FREQ_W-1:0]   c_freq2_reg;

    logic [PROD_W:0]     fsum;
    logic [PROD_W:0]     f2sum;

    assign fsum  = (PROD_W+1)'(b_fprod_reg) + HALF_F;
    assign f2sum = (PROD_W+1)'(b_f2prod_reg) + HALF_F;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_v_reg      <= speed;
        a_rgn_reg    <= rgn_in;

        b_v_reg      <= a_v_reg;
        b_rgn_reg    <= a_rgn_reg;
        b_step_reg   <= STEP_W'(eff_span) * STEP_W'(a_v_reg - speed_one_reg);
        b_f0s1_reg   <= PW1_W'(max_force_reg) * PW1_W'(s1_sel);
        b_fprod_reg  <= PROD_W'(stf_reg) * PROD_W'(a_v_reg);
        b_f2prod_reg <= PROD_W'(stf_reg) * PROD_W'(speed_two_reg);

        c_v_reg      <= b_v_reg;
        c_rgn_reg    <= b_rgn_reg;
        c_step_reg   <= b_step_reg;
        c_numa_reg   <= NUMA_W'(b_f0s1_reg) * NUMA_W'(e1);
        c_freq_reg   <= FREQ_W'(fsum[PROD_W:8+SFB]) + FREQ_W'(slip_reg);
        c_freq2_reg  <= FREQ_W'(f2sum[PROD_W:8+SFB]) + FREQ_W'(slip_reg);
    end

    // efficiency interpolation step
    side_i_t          side_i_in;
    side_i_t          side_i_out;
    logic [$bits(side_i_t)-1:0] side_i_vec;
    logic             i_vld;
    logic [EFF_W-1:0] q_i;
    logic             ovf_i;

    assign side_i_in = '{num_a: c_numa_reg, freq: c_freq_reg, freq_two: c_freq2_reg,
                         v: c_v_reg, rgn: c_rgn_reg};

    tfc_div #(
        .NUM_W  (STEP_W),
        .DEN_W  (SPEED_W),
        .QUO_W  (EFF_W),
        .SIDE_W ($bits(side_i_t))
    ) u_div_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_vld_reg),
        .num       (c_step_reg),
        .den       (speed_span),
        .side_in   (side_i_in),
        .out_valid (i_vld),
        .quo       (q_i),
        .ovf       (ovf_i),
        .side_out  (side_i_vec)
    );

    assign side_i_out = side_i_t'(side_i_vec);

    // stages D, E, F
    logic                d_vld_reg;
    logic [EFF_W-1:0]    d_eff_reg;
    logic [SPEED_W-1:0]  d_x_reg;
    side_i_t             d_side_reg;
    logic                e_vld_reg;
    logic [DENA_W-1:0]   e_dena_reg;
    logic [EFF_W-1:0]    e_eff_reg;
    side_i_t             e_side_reg;
    logic                f_vld_reg;
    logic [NUMA_W:0]     f_numa_reg;
    logic [DENA_W-1:0]   f_dena_reg;
    side_a_t             f_side_reg;

    logic [EFF_W:0]      interp_eff;
    logic [EFF_W-1:0]    eff_next;

    assign interp_eff = eff_falls ? ((EFF_W+1)'(e1) - (EFF_W+1)'(q_i))
                                  : ((EFF_W+1)'(e1) + (EFF_W+1)'(q_i));

    always_comb
    begin
        case (side_i_out.rgn)
            REGION_CONST:  eff_next = e1;
            REGION_INTERP: eff_next = interp_eff[EFF_W-1:0];
            default:       eff_next = e2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= i_vld;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_eff_reg  <= eff_next;
        d_x_reg    <= (side_i_out.rgn == REGION_INVSQ) ? s2_sel : side_i_out.v;
        d_side_reg <= side_i_out;

        e_dena_reg <= DENA_W'(d_x_reg) * DENA_W'(d_eff_reg);
        e_eff_reg  <= d_eff_reg;
        e_side_reg <= d_side_reg;

        f_numa_reg <= (NUMA_W+1)'(e_side_reg.num_a) + (NUMA_W+1)'(e_dena_reg >> 1);
        f_dena_reg <= e_dena_reg;
        f_side_reg <= '{freq: e_side_reg.freq, freq_two: e_side_reg.freq_two,
                        v: e_side_reg.v, rgn: e_side_reg.rgn, eff: e_eff_reg};
    end

    // force at speed one over speed (or at speed two)
    side_a_t            side_a_out;
    logic [$bits(side_a_t)-1:0] side_a_vec;
    logic               a_out_vld;
    logic [FORCE_W-1:0] q_a;
    logic               ovf_a;

    tfc_div #(
        .NUM_W  (NUMA_W + 1),
        .DEN_W  (DENA_W),
        .QUO_W  (FORCE_W),
        .SIDE_W ($bits(side_a_t))
    ) u_div_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld_reg),
        .num       (f_numa_reg),
        .den       (f_dena_reg),
        .side_in   (f_side_reg),
        .out_valid (a_out_vld),
        .quo       (q_a),
        .ovf       (ovf_a),
        .side_out  (side_a_vec)
    );

    assign side_a_out = side_a_t'(side_a_vec);

    // stages G, H
    logic               g_vld_reg;
    logic [TN_W-1:0]    g_tnum_reg;
    side_b_t            g_side_reg;
    logic               h_vld_reg;
    logic [TN_W:0]      h_tnum_reg;
    side_b_t            h_side_reg;

    logic [FORCE_W-1:0] force_a;
    logic [FORCE_W-1:0] force_early;

    assign force_a = ovf_a ? FORCE_MAX : q_a;

    always_comb
    begin
        case (side_a_out.rgn)
            REGION_CONST:  force_early = max_force_reg;
            REGION_INTERP: force_early = (side_a_out.v == '0) ? max_force_reg : force_a;
            default:       force_early = force_a;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
        end
        else
        begin
            g_vld_reg <= a_out_vld;
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g_tnum_reg <= TN_W'(force_a) * TN_W'(side_a_out.freq_two);
        g_side_reg <= '{force_e: force_early, freq: side_a_out.freq,
                        freq_two: side_a_out.freq_two, v: side_a_out.v,
                        rgn: side_a_out.rgn, eff: side_a_out.eff};

        h_tnum_reg <= (TN_W+1)'(g_tnum_reg) + (TN_W+1)'(g_side_reg.freq >> 1);
        h_side_reg <= g_side_reg;
    end

    // first frequency ratio step
    side_b_t            side_b_out;
    logic [$bits(side_b_t)-1:0] side_b_vec;
    logic               b_out_vld;
    logic [FORCE_W-1:0] q_b;
    logic               ovf_b;

    tfc_div #(
        .NUM_W  (TN_W + 1),
        .DEN_W  (FREQ_W),
        .QUO_W  (FORCE_W),
        .SIDE_W ($bits(side_b_t))
    ) u_div_ratio1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_vld_reg),
        .num       (h_tnum_reg),
        .den       (h_side_reg.freq),
        .side_in   (h_side_reg),
        .out_valid (b_out_vld),
        .quo       (q_b),
        .ovf       (ovf_b),
        .side_out  (side_b_vec)
    );

    assign side_b_out = side_b_t'(side_b_vec);

    // stages I, J
    logic               i_vld_reg;
    logic [TN_W-1:0]    i_tnum_reg;
    logic [FREQ_W-1:0]  i_freq_reg;
    side_c_t            i_side_reg;
    logic               j_vld_reg;
    logic [TN_W:0]      j_tnum_reg;
    logic [FREQ_W-1:0]  j_freq_reg;
    side_c_t            j_side_reg;

    logic [FORCE_W-1:0] t_mid;

    // a zero frequency only comes with the ratio bypass below
    assign t_mid = ovf_b ? FORCE_MAX : q_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
        end
        else
        begin
            i_vld_reg <= b_out_vld;
            j_vld_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i_tnum_reg <= TN_W'(t_mid) * TN_W'(side_b_out.freq_two);
        i_freq_reg <= side_b_out.freq;
        i_side_reg <= '{force_e: side_b_out.force_e, fz: (side_b_out.freq == '0),
                        v: side_b_out.v, rgn: side_b_out.rgn, eff: side_b_out.eff};

        j_tnum_reg <= (TN_W+1)'(i_tnum_reg) + (TN_W+1)'(i_freq_reg >> 1);
        j_freq_reg <= i_freq_reg;
        j_side_reg <= i_side_reg;
    end

    // second frequency ratio step
    side_c_t            side_c_out;
    logic [$bits(side_c_t)-1:0] side_c_vec;
    logic               c_out_vld;
    logic [FORCE_W-1:0] q_c;
    logic               ovf_c;

    tfc_div #(
        .NUM_W  (TN_W + 1),
        .DEN_W  (FREQ_W),
        .QUO_W  (FORCE_W),
        .SIDE_W ($bits(side_c_t))
    ) u_div_ratio2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (j_vld_reg),
        .num       (j_tnum_reg),
        .den       (j_freq_reg),
        .side_in   (j_side_reg),
        .out_valid (c_out_vld),
        .quo       (q_c),
        .ovf       (ovf_c),
        .side_out  (side_c_vec)
    );

    assign side_c_out = side_c_t'(side_c_vec);

    // stages K, L, M, N: final force, then power
    logic                k_vld_reg;
    logic [FORCE_W-1:0]  k_force_reg;
    logic [SPEED_W-1:0]  k_v_reg;
    logic [REGION_W-1:0] k_rgn_reg;
    logic [EFF_W-1:0]    k_eff_reg;
    logic                l_vld_reg;
    logic [PW1_W-1:0]    l_pw_reg;
    logic [PD0_W-1:0]    l_pden_reg;
    side_p_t             l_side_reg;
    logic                m_vld_reg;
    logic [PW_W-1:0]     m_pw_reg;
    logic [PDEN_W-1:0]   m_pden_reg;
    side_p_t             m_side_reg;
    logic                n_vld_reg;
    logic [PW_W:0]       n_pnum_reg;
    logic [PDEN_W-1:0]   n_pden_reg;
    side_p_t             n_side_reg;

    logic [FORCE_W-1:0]  force_fin;

    assign force_fin = (side_c_out.rgn == REGION_INVSQ && !side_c_out.fz)
                       ? (ovf_c ? FORCE_MAX : q_c) : side_c_out.force_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_vld_reg <= 1'b0;
            l_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
        end
        else
        begin
            k_vld_reg <= c_out_vld;
            l_vld_reg <= k_vld_reg;
            m_vld_reg <= l_vld_reg;
            n_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k_force_reg <= force_fin;
        k_v_reg     <= side_c_out.v;
        k_rgn_reg   <= side_c_out.rgn;
        k_eff_reg   <= side_c_out.eff;

        l_pw_reg    <= PW1_W'(k_force_reg) * PW1_W'(k_v_reg);
        l_pden_reg  <= PD0_W'(k_eff_reg) * PD0_W'(SEC_PER_HOUR);
        l_side_reg  <= '{frc: k_force_reg, rgn: k_rgn_reg};

        m_pw_reg    <= PW_W'(l_pw_reg) * PW_W'(GRAV_Q16);
        m_pden_reg  <= PDEN_W'(l_pden_reg) << SFB;
        m_side_reg  <= l_side_reg;

        n_pnum_reg  <= (PW_W+1)'(m_pw_reg) + (PW_W+1)'(m_pden_reg >> 1);
        n_pden_reg  <= m_pden_reg;
        n_side_reg  <= m_side_reg;
    end

    // power
    side_p_t            side_p_out;
    logic [$bits(side_p_t)-1:0] side_p_vec;
    logic               p_out_vld;
    logic [POWER_W-1:0] q_p;
    logic               ovf_p;

    tfc_div #(
        .NUM_W  (PW_W + 1),
        .DEN_W  (PDEN_W),
        .QUO_W  (POWER_W),
        .SIDE_W ($bits(side_p_t))
    ) u_div_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n_vld_reg),
        .num       (n_pnum_reg),
        .den       (n_pden_reg),
        .side_in   (n_side_reg),
        .out_valid (p_out_vld),
        .quo       (q_p),
        .ovf       (ovf_p),
        .side_out  (side_p_vec)
    );

    assign side_p_out = side_p_t'(side_p_vec);

    logic                done_reg;
    logic [FORCE_W-1:0]  force_res_reg;
    logic [POWER_W-1:0]  power_reg;
    logic [REGION_W-1:0] region_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= p_out_vld;
    end

    always_ff @(posedge clk)
    begin
        force_res_reg <= side_p_out.frc;
        power_reg     <= ovf_p ? POWER_MAX : q_p;
        region_reg    <= side_p_out.rgn;
    end

    assign done      = done_reg;
    assign force_res = force_res_reg;
    assign power     = power_reg;
    assign region    = region_reg;

`ifndef SYNTHESIS
    a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##118 done)
        else $error("accepted transaction did not complete on time");

    a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##118 !done)
        else $error("result strobe without a matching transaction");

    a_zero_force_power: assert property (@(posedge clk) disable iff (!rst_n)
        done && force_res == '0 |-> power == '0)
        else $error("nonzero power with zero force");
`endif

endmodule

// ===== sv/tfc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// ovf flags a quotient that does not fit in QUO_W bits (or a zero divisor).
module tfc_div #(
    parameter int NUM_W  = 53,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 20,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic              ovf,
    output logic [SIDE_W-1:0] side_out
);

    localparam int HI_W   = NUM_W - QUO_W;
    localparam int CW     = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int STAGES = QUO_W + 1;

    logic              val_reg  [STAGES];
    logic [DEN_W-1:0]  rem_reg  [STAGES];
    logic [QUO_W-1:0]  work_reg [STAGES];
    logic [DEN_W-1:0]  den_reg  [STAGES];
    logic              ovf_reg  [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    logic [CW-1:0]    hi_ext;
    logic [CW-1:0]    den_ext;
    logic [DEN_W:0]   trial     [QUO_W];
    logic [DEN_W:0]   sub       [QUO_W];
    logic             take      [QUO_W];
    logic [DEN_W-1:0] rem_next  [QUO_W];
    logic [QUO_W-1:0] work_next [QUO_W];

    assign hi_ext  = CW'(num[NUM_W-1:QUO_W]);
    assign den_ext = CW'(den);

    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            trial[k]     = {rem_reg[k], work_reg[k][QUO_W-1]};
            take[k]      = trial[k] >= {1'b0, den_reg[k]};
            sub[k]       = trial[k] - {1'b0, den_reg[k]};
            rem_next[k]  = take[k] ? sub[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
            work_next[k] = {work_reg[k][QUO_W-2:0], take[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                val_reg[s] <= 1'b0;
            end
        end
        else
        begin
            val_reg[0] <= in_valid;
            for (int s = 1; s < STAGES; s++)
            begin
                val_reg[s] <= val_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= hi_ext[DEN_W-1:0];
        work_reg[0] <= num[QUO_W-1:0];
        den_reg[0]  <= den;
        ovf_reg[0]  <= hi_ext >= den_ext;
        side_reg[0] <= side_in;
        for (int s = 1; s < STAGES; s++)
        begin
            rem_reg[s]  <= rem_next[s-1];
            work_reg[s] <= work_next[s-1];
            den_reg[s]  <= den_reg[s-1];
            ovf_reg[s]  <= ovf_reg[s-1];
            side_reg[s] <= side_reg[s-1];
        end
    end

    assign out_valid = val_reg[QUO_W];
    assign quo       = work_reg[QUO_W];
    assign ovf       = ovf_reg[QUO_W];
    assign side_out  = side_reg[QUO_W];

endmodule

// ===== tb/traction_force_curve_checker.sv =====
`timescale 1ns / 100ps
module traction_force_curve_checker
    import tfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [SPEED_W-1:0]    speed,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  done,
    input  logic [FORCE_W-1:0]    force_res,
    input  logic [POWER_W-1:0]    power,
    input  logic [REGION_W-1:0]   region,
    output int                    errors,
    output int                    pending
);

    localparam int SFB = SPEED_FRAC_BITS_DEF;

    typedef struct packed {
        logic [FORCE_W-1:0]  force_val;
        logic [POWER_W-1:0]  power_val;
        logic [REGION_W-1:0] region_val;
    } curve_point_t;

    logic [FORCE_W-1:0] max_force_r;
    logic [SPEED_W-1:0] speed_one_r, speed_two_r;
    logic [EFF_W-1:0]   eff_low_r, eff_high_r;
    logic [STF_W-1:0]   stf_r;
    logic [SLIP_W-1:0]  slip_r;

    curve_point_t expected_points[$];

    assign pending = expected_points.size();

    function automatic longint unsigned div_round(longint unsigned num,
                                                  longint unsigned den);
        if (den == 0)
            return 0;
        return (num + den / 2) / den;
    endfunction

    function automatic longint unsigned clamp(longint unsigned v, longint unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic longint unsigned freq_at(longint unsigned v);
        longint unsigned prod;
        prod = 64'(stf_r) * v;
        return ((prod + (64'd1 << (7 + SFB))) >> (8 + SFB)) + 64'(slip_r);
    endfunction

    function automatic curve_point_t curve_point(logic [SPEED_W-1:0] spd);
        longint unsigned v, s1, s2, e1, e2, f0, frc, eff, fa, fq2, fq, t;
        longint signed diff, stepv, c;
        curve_point_t p;
        v  = 64'(spd);
        s1 = 64'(speed_one_r);
        s2 = 64'(speed_two_r);
        f0 = 64'(max_force_r);
        e1 = (eff_low_r == '0) ? 64'd1 : 64'(eff_low_r);
        e2 = (eff_high_r == '0) ? 64'd1 : 64'(eff_high_r);
        if (v < s1)
        begin
            p.region_val = REGION_CONST;
            frc = f0;
            eff = e1;
        end
        else if (v < s2 && s1 < s2)
        begin
            diff  = longint'(e2) - longint'(e1);
            stepv = diff * longint'(v - s1);
            c     = longint'(e1) + stepv / longint'(s2 - s1);
            p.region_val = REGION_INTERP;
            eff = unsigned'(c);
            if (v == 0)
                frc = f0;
            else
                frc = clamp(div_round(f0 * s1 * e1, v * eff), 64'(FORCE_MAX));
        end
        else
        begin
            p.region_val = REGION_INVSQ;
            eff = e2;
            if (s2 == 0)
                fa = div_round(f0 * e1, e2);
            else
                fa = div_round(f0 * s1 * e1, s2 * e2);
            fa  = clamp(fa, 64'(FORCE_MAX));
            fq2 = freq_at(s2);
            fq  = freq_at(v);
            if (fq == 0)
                frc = fa;
            else
            begin
                t   = div_round(fa * fq2, fq);
                frc = clamp(div_round(t * fq2, fq), 64'(FORCE_MAX));
            end
        end
        p.force_val = FORCE_W'(frc);
        p.power_val = POWER_W'(clamp(div_round(frc * v * 64'(GRAV_Q16),
                                               (eff * 64'(SEC_PER_HOUR)) << SFB),
                                     64'(POWER_MAX)));
        return p;
    endfunction

    task automatic report(string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_force_r <= '0;
            speed_one_r <= '0;
            speed_two_r <= '0;
            eff_low_r   <= EFF_LOW_RST;
            eff_high_r  <= EFF_HIGH_RST;
            stf_r       <= '0;
            slip_r      <= SLIP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_MAX_FORCE:     max_force_r <= cfg_data[FORCE_W-1:0];
                CFG_SPEED_ONE:     speed_one_r <= cfg_data[SPEED_W-1:0];
                CFG_SPEED_TWO:     speed_two_r <= cfg_data[SPEED_W-1:0];
                CFG_EFF_LOW:       eff_low_r   <= cfg_data[EFF_W-1:0];
                CFG_EFF_HIGH:      eff_high_r  <= cfg_data[EFF_W-1:0];
                CFG_SPEED_TO_FREQ: stf_r       <= cfg_data[STF_W-1:0];
                CFG_SLIP_FREQ_TWO: slip_r      <= cfg_data[SLIP_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        curve_point_t exp_p;
        if (rst_n)
        begin
            if (start && !busy)
                expected_points.push_back(curve_point(speed));
            if (done)
            begin
                if (expected_points.size() == 0)
                    report("result with no transaction outstanding");
                else
                begin
                    exp_p = expected_points.pop_front();
                    if (force_res !== exp_p.force_val)
                        report($sformatf("force_res %0d, expected %0d",
                                         force_res, exp_p.force_val));
                    if (power !== exp_p.power_val)
                        report($sformatf("power %0d, expected %0d", power, exp_p.power_val));
                    if (region !== exp_p.region_val)
                        report($sformatf("region %0d, expected %0d",
                                         region, exp_p.region_val));
                end
            end
        end
    end

endmodule

// ===== tb/traction_force_curve_unit_tb.sv =====
`timescale 1ns / 100ps
module traction_force_curve_unit_tb;
    import tfc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 140;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [SPEED_W-1:0]    speed;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic [FORCE_W-1:0]    force_res;
    logic [POWER_W-1:0]    power;
    logic [REGION_W-1:0]   region;
    int                    errors;
    int                    pending;

    // copies used only to aim speeds at the region edges
    int unsigned s1_now, s2_now;

    traction_force_curve_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .speed(speed),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .done(done),
        .force_res(force_res), .power(power), .region(region)
    );

    traction_force_curve_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .speed(speed),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .done(done),
        .force_res(force_res), .power(power), .region(region),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
        if (idx == CFG_SPEED_ONE) s1_now = val & 32'hFFFF;
        if (idx == CFG_SPEED_TWO) s2_now = val & 32'hFFFF;
    endtask

    task automatic load_curve(int unsigned f0, int unsigned s1, int unsigned s2,
                              int unsigned el, int unsigned eh, int unsigned stf,
                              int unsigned slip);
        drain();
        write_reg(CFG_MAX_FORCE, f0);
        write_reg(CFG_SPEED_ONE, s1);
        write_reg(CFG_SPEED_TWO, s2);
        write_reg(CFG_EFF_LOW, el);
        write_reg(CFG_EFF_HIGH, eh);
        write_reg(CFG_SPEED_TO_FREQ, stf);
        write_reg(CFG_SLIP_FREQ_TWO, slip);
        // unused index must leave everything untouched
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // one transaction; start stays high across back-to-back calls
    task automatic send(logic [SPEED_W-1:0] v);
        bit ok;
        start <= 1'b1;
        speed <= v;
        do
        begin
            ok = !busy;
            @(posedge clk);
        end
        while (!ok);
    endtask

    task automatic pause(int unsigned n);
        start <= 1'b0;
        speed <= SPEED_W'($urandom);
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [SPEED_W-1:0] pick_speed();
        int unsigned e;
        case ($urandom_range(0, 5))
            0: e = s1_now;
            1: e = s2_now;
            2: e = ($urandom_range(0, 3) == 0) ? 0 : 65535;
            default: return SPEED_W'($urandom);
        endcase
        return SPEED_W'(e + $urandom_range(0, 8) - 4);
    endfunction

    task automatic run_phase(int unsigned n_random);
        int unsigned left, burst;
        send(SPEED_W'(0));
        send(16'hFFFF);
        send(SPEED_W'(1));
        send(16'h8000);
        send(16'h7FFF);
        send(16'h5555);
        send(16'hAAAA);
        send(SPEED_W'(s1_now - 1));
        send(SPEED_W'(s1_now));
        send(SPEED_W'(s1_now + 1));
        send(SPEED_W'(s2_now - 1));
        send(SPEED_W'(s2_now));
        send(SPEED_W'(s2_now + 1));
        pause(3);
        left = n_random;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            repeat (burst) send(pick_speed());
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 12));
        end
        pause(1);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        speed    = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        s1_now   = 0;
        s2_now   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults
        run_phase(100);
        // typical drive: 30 / 80 km/h, eff 0.95 / 0.90
        load_curve(250000, 30 << 8, 80 << 8, 62259, 58982, 20000, 1638);
        run_phase(220);
        // everything at maximum
        load_curve(20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        run_phase(130);
        // zero efficiencies and speed_one, zero frequency everywhere
        load_curve(20'hFFFFF, 0, 16'h4000, 0, 0, 0, 0);
        run_phase(130);
        // speed_two below speed_one, rising efficiency
        load_curve(123456, 16'h6000, 16'h2000, 1, 16'hFFFF, 24'hFFFFFF, 0);
        run_phase(130);
        // tiny efficiencies push force and power into saturation
        load_curve(20'hFFFFF, 16'h0100, 16'hF000, 1, 2, 300, 16'hFFFF);
        run_phase(130);
        repeat (5)
        begin
            load_curve($urandom_range(0, 20'hFFFFF), $urandom_range(0, 16'h8000),
                       $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                       $urandom_range(0, 16'hFFFF), $urandom_range(0, 24'hFFFFFF),
                       $urandom_range(0, 16'hFFFF));
            run_phase(130);
        end

        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
